// ===== rtl/pfa_pkg.sv =====
// Shared types and constants for the page frame allocator.
`timescale 1ns / 1ps
package pfa_pkg;

    localparam int DIR_BITS   = 10;
    localparam int DIR_N      = 1 << DIR_BITS;
    localparam int TBL_BITS   = 10;
    localparam int TBL_N      = 1 << TBL_BITS;
    localparam int SLOT_BITS  = DIR_BITS + TBL_BITS;
    localparam int WORD_W     = 64;
    localparam int WBIT_BITS  = 6;
    localparam int CNT_W      = DIR_BITS + 1;
    localparam logic [31:0] KERNEL_LIMIT = 32'hC000_0000;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_MAP   = 2'd2;

    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_KERNEL     = 3'd1;
    localparam logic [2:0] ST_LARGE      = 3'd2;
    localparam logic [2:0] ST_MAPPED     = 3'd3;
    localparam logic [2:0] ST_NO_FRAME   = 3'd4;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd5;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIR_RD,
        S_DIR_CHK,
        S_TBL_CLR,
        S_SCAN,
        S_FREE_WR,
        S_MAP,
        S_RESP
    } t_state;

    typedef struct packed {
        logic                present;
        logic                lpage;
        logic                user;
        logic [DIR_BITS-1:0] base;
    } t_dir_entry;

    typedef struct packed {
        logic                 has_free;
        logic [WBIT_BITS-1:0] first_free;
    } t_bm_rsp;

endpackage

// ===== rtl/pfa_bitmap.sv =====
// Frame-use bitmap memory with first-free-bit search on the read word.
`timescale 1ns / 1ps
module pfa_bitmap #(
    parameter int WORDS = 64,
    parameter int WB    = 6
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [WB-1:0]               i_wr_addr,
    input  logic [pfa_pkg::WORD_W-1:0]  i_wr_data,
    input  logic [WB-1:0]               i_rd_addr,
    output logic [pfa_pkg::WORD_W-1:0]  o_rd_data,
    output pfa_pkg::t_bm_rsp            o_rsp
);

    logic [pfa_pkg::WORD_W-1:0] r_mem [WORDS];
    logic [pfa_pkg::WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

    // lowest clear bit
    always_comb begin
        o_rsp = '0;
        for (int b = pfa_pkg::WORD_W - 1; b >= 0; b--) begin
            if (!r_rd_data[b]) begin
                o_rsp.has_free   = 1'b1;
                o_rsp.first_free = pfa_pkg::WBIT_BITS'(b);
            end
        end
    end

endmodule

// ===== rtl/pfa_dir.sv =====
// Page directory memory: present, large, user flags and large-page base.
`timescale 1ns / 1ps
module pfa_dir (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [pfa_pkg::DIR_BITS-1:0]  i_wr_addr,
    input  pfa_pkg::t_dir_entry           i_wr_data,
    input  logic [pfa_pkg::DIR_BITS-1:0]  i_rd_addr,
    output pfa_pkg::t_dir_entry           o_rd_data
);

    pfa_pkg::t_dir_entry r_mem [pfa_pkg::DIR_N];
    pfa_pkg::t_dir_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/pfa_table.sv =====
// Page table entry memory: present flag and frame number per 4 KiB slot.
`timescale 1ns / 1ps
module pfa_table #(
    parameter int FW = 12
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [pfa_pkg::SLOT_BITS-1:0]  i_wr_addr,
    input  logic                           i_wr_present,
    input  logic [FW-1:0]                  i_wr_frame,
    input  logic [pfa_pkg::SLOT_BITS-1:0]  i_rd_addr,
    output logic                           o_rd_present,
    output logic [FW-1:0]                  o_rd_frame
);

    logic [FW:0] r_mem [1 << pfa_pkg::SLOT_BITS];
    logic [FW:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_present, i_wr_frame};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_present = r_rd_data[FW];
    assign o_rd_frame   = r_rd_data[FW-1:0];

endmodule

// ===== rtl/page_frame_allocator_with_map.sv =====
// Top level: page frame allocator with a two-level page map.
//
//  channel | signals                                     | dir | transaction
//  --------+---------------------------------------------+-----+-----------------------
//  in      | i_in_valid/o_in_ready, command, addresses   | in  | one command
//  out     | o_out_valid/i_out_ready, status, frame      | out | one result per command
//
// Allocate: the bitmap is scanned one 64-bit word per cycle, pipelined behind the
// registered memory read; when the table is created its entries are first swept clear.
// Map-large makes one directory write per cycle for each mapped entry.
// Reset: a clearing pass writes the directory and the bitmap; no command is taken
// until it ends. The table memory needs no pass.
// Stalls: one command at a time; a finished result waits in the output register
// while the next command is accepted. FRAMES must be a power of two; the block does
// not check it.
`timescale 1ns / 1ps
module page_frame_allocator_with_map #(
    parameter int FRAMES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_virt_addr,
    input  logic [31:0] i_phys_addr,
    input  logic [31:0] i_length_bytes,
    input  logic        i_user_access,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [11:0] o_frame
);

    localparam int WORDS  = FRAMES / pfa_pkg::WORD_W;
    localparam int WB     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FW     = $clog2(FRAMES);
    localparam int QUART  = FRAMES / 4;
    localparam int QWORDS = QUART / pfa_pkg::WORD_W;
    localparam int QREM   = QUART % pfa_pkg::WORD_W;
    localparam int INIT_N = (WORDS > pfa_pkg::DIR_N) ? WORDS : pfa_pkg::DIR_N;
    localparam int IB     = $clog2(INIT_N) + 1;
    localparam logic [pfa_pkg::WORD_W-1:0] QMASK =
        (pfa_pkg::WORD_W'(1) << QREM) - pfa_pkg::WORD_W'(1);

    pfa_pkg::t_state r_state, n_state;

    // captured command
    logic [1:0]                   r_cmd;
    logic [31:0]                  r_va;
    logic [pfa_pkg::DIR_BITS-1:0] r_base;
    logic                         r_user;
    logic [pfa_pkg::CNT_W-1:0]    r_left;
    logic [pfa_pkg::CNT_W-1:0]    r_mapd;

    // sequencer counters
    logic [IB-1:0]                r_icnt;
    logic [pfa_pkg::CNT_W-1:0]    r_tc;
    logic [WB:0]                  r_widx;
    logic [WB-1:0]                r_cidx;
    logic                         r_chk;

    // pending result and output register
    logic [2:0]                   r_res_status;
    logic [FW-1:0]                r_res_frame;
    logic                         r_out_valid;
    logic [2:0]                   r_status;
    logic [11:0]                  r_frame;

    // memory ports
    logic                          bm_wr_en;
    logic [WB-1:0]                 bm_wr_addr, bm_rd_addr;
    logic [pfa_pkg::WORD_W-1:0]    bm_wr_data, bm_rd_data;
    pfa_pkg::t_bm_rsp              bm_rsp;
    logic                          dir_wr_en;
    logic [pfa_pkg::DIR_BITS-1:0]  dir_wr_addr, dir_rd_addr;
    pfa_pkg::t_dir_entry           dir_wr_data, dir_rd;
    logic                          tb_wr_en, tb_wr_present, tb_rd_present;
    logic [pfa_pkg::SLOT_BITS-1:0] tb_wr_addr, tb_rd_addr;
    logic [FW-1:0]                 tb_wr_frame, tb_rd_frame;

    logic [pfa_pkg::DIR_BITS-1:0]  va_dir;
    logic [pfa_pkg::SLOT_BITS-1:0] va_slot;
    logic                          in_acc;
    logic                          out_load;
    logic                          scan_hit;
    logic                          scan_end;
    logic                          map_end;
    logic                          init_end;
    logic [FW-1:0]                 hit_frame;
    logic [WB-1:0]                 init_word;
    logic [pfa_pkg::WORD_W-1:0]    init_data;

    assign va_dir    = r_va[31:22];
    assign va_slot   = r_va[31:12];
    assign in_acc    = i_in_valid && o_in_ready;
    assign out_load  = !r_out_valid || i_out_ready;
    assign scan_hit  = r_chk && bm_rsp.has_free;
    assign scan_end  = (r_widx == (WB + 1)'(WORDS)) && !r_chk;
    assign map_end   = (r_left == '0) || r_mapd[pfa_pkg::DIR_BITS];
    assign init_end  = (r_icnt == IB'(INIT_N - 1));
    assign hit_frame = FW'({r_cidx, bm_rsp.first_free});
    assign init_word = WB'(r_icnt);

    // reset value of a bitmap word: the first quarter of frames is reserved
    always_comb begin
        if (r_icnt < IB'(QWORDS)) begin
            init_data = '1;
        end else if (r_icnt == IB'(QWORDS)) begin
            init_data = QMASK;
        end else begin
            init_data = '0;
        end
    end

    pfa_bitmap #(.WORDS(WORDS), .WB(WB)) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (bm_wr_en),
        .i_wr_addr (bm_wr_addr),
        .i_wr_data (bm_wr_data),
        .i_rd_addr (bm_rd_addr),
        .o_rd_data (bm_rd_data),
        .o_rsp     (bm_rsp)
    );

    pfa_dir u_dir (
        .i_clk     (i_clk),
        .i_wr_en   (dir_wr_en),
        .i_wr_addr (dir_wr_addr),
        .i_wr_data (dir_wr_data),
        .i_rd_addr (dir_rd_addr),
        .o_rd_data (dir_rd)
    );

    pfa_table #(.FW(FW)) u_table (
        .i_clk        (i_clk),
        .i_wr_en      (tb_wr_en),
        .i_wr_addr    (tb_wr_addr),
        .i_wr_present (tb_wr_present),
        .i_wr_frame   (tb_wr_frame),
        .i_rd_addr    (tb_rd_addr),
        .o_rd_present (tb_rd_present),
        .o_rd_frame   (tb_rd_frame)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfa_pkg::S_INIT: begin
                if (init_end) n_state = pfa_pkg::S_IDLE;
            end
            pfa_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_command)
                        pfa_pkg::CMD_ALLOC: begin
                            n_state = (i_virt_addr > pfa_pkg::KERNEL_LIMIT) ?
                                      pfa_pkg::S_RESP : pfa_pkg::S_DIR_RD;
                        end
                        pfa_pkg::CMD_FREE: n_state = pfa_pkg::S_DIR_RD;
                        pfa_pkg::CMD_MAP:  n_state = pfa_pkg::S_MAP;
                        default:           n_state = pfa_pkg::S_RESP;
                    endcase
                end
            end
            pfa_pkg::S_DIR_RD: n_state = pfa_pkg::S_DIR_CHK;
            pfa_pkg::S_DIR_CHK: begin
                if (r_cmd == pfa_pkg::CMD_ALLOC) begin
                    if (!dir_rd.present) begin
                        n_state = pfa_pkg::S_TBL_CLR;
                    end else if (dir_rd.lpage || tb_rd_present) begin
                        n_state = pfa_pkg::S_RESP;
                    end else begin
                        n_state = pfa_pkg::S_SCAN;
                    end
                end else begin
                    if (dir_rd.present && !dir_rd.lpage && tb_rd_present) begin
                        n_state = pfa_pkg::S_FREE_WR;
                    end else begin
                        n_state = pfa_pkg::S_RESP;
                    end
                end
            end
            pfa_pkg::S_TBL_CLR: begin
                if (r_tc == pfa_pkg::CNT_W'(pfa_pkg::TBL_N - 1)) n_state = pfa_pkg::S_SCAN;
            end
            pfa_pkg::S_SCAN: begin
                if (scan_hit || scan_end) n_state = pfa_pkg::S_RESP;
            end
            pfa_pkg::S_FREE_WR: n_state = pfa_pkg::S_RESP;
            pfa_pkg::S_MAP: begin
                if (map_end) n_state = pfa_pkg::S_RESP;
            end
            pfa_pkg::S_RESP: begin
                if (out_load) n_state = pfa_pkg::S_IDLE;
            end
            default: n_state = pfa_pkg::S_INIT;
        endcase
    end

    // memory controls
    always_comb begin
        o_in_ready    = 1'b0;
        bm_wr_en      = 1'b0;
        bm_wr_addr    = r_cidx;
        bm_wr_data    = bm_rd_data;
        bm_rd_addr    = r_widx[WB-1:0];
        dir_wr_en     = 1'b0;
        dir_wr_addr   = va_dir;
        dir_wr_data   = '0;
        dir_rd_addr   = va_dir;
        tb_wr_en      = 1'b0;
        tb_wr_addr    = va_slot;
        tb_wr_present = 1'b0;
        tb_wr_frame   = '0;
        tb_rd_addr    = va_slot;
        case (r_state)
            pfa_pkg::S_INIT: begin
                dir_wr_en   = (r_icnt < IB'(pfa_pkg::DIR_N));
                dir_wr_addr = pfa_pkg::DIR_BITS'(r_icnt);
                bm_wr_en    = (r_icnt < IB'(WORDS));
                bm_wr_addr  = init_word;
                bm_wr_data  = init_data;
            end
            pfa_pkg::S_IDLE: o_in_ready = 1'b1;
            pfa_pkg::S_DIR_CHK: begin
                if (r_cmd == pfa_pkg::CMD_ALLOC) begin
                    // new table directory entry
                    dir_wr_en   = !dir_rd.present;
                    dir_wr_data = '{present: 1'b1, lpage: 1'b0, user: 1'b1, base: '0};
                end else begin
                    tb_wr_en   = dir_rd.present && !dir_rd.lpage && tb_rd_present;
                    bm_rd_addr = WB'(tb_rd_frame >> pfa_pkg::WBIT_BITS);
                end
            end
            pfa_pkg::S_TBL_CLR: begin
                tb_wr_en   = 1'b1;
                tb_wr_addr = {va_dir, r_tc[pfa_pkg::TBL_BITS-1:0]};
            end
            pfa_pkg::S_SCAN: begin
                bm_wr_en      = scan_hit;
                bm_wr_data    = bm_rd_data |
                                (pfa_pkg::WORD_W'(1) << bm_rsp.first_free);
                tb_wr_en      = scan_hit;
                tb_wr_present = 1'b1;
                tb_wr_frame   = hit_frame;
            end
            pfa_pkg::S_FREE_WR: begin
                bm_wr_en   = 1'b1;
                bm_wr_addr = WB'(r_res_frame >> pfa_pkg::WBIT_BITS);
                bm_wr_data = bm_rd_data & ~(pfa_pkg::WORD_W'(1) <<
                                            r_res_frame[pfa_pkg::WBIT_BITS-1:0]);
            end
            pfa_pkg::S_MAP: begin
                dir_wr_en   = !map_end;
                dir_wr_addr = r_mapd[pfa_pkg::DIR_BITS-1:0];
                dir_wr_data = '{present: 1'b1, lpage: 1'b1, user: r_user, base: r_base};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfa_pkg::S_INIT;
            r_icnt      <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
        end else begin
            r_state <= n_state;
            // output register: load a finished result, drop on transaction
            if (r_state == pfa_pkg::S_RESP && out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                pfa_pkg::S_INIT: r_icnt <= r_icnt + IB'(1);
                pfa_pkg::S_IDLE: begin
                    r_cmd        <= i_command;
                    r_va         <= i_virt_addr;
                    r_base       <= i_phys_addr[31:22];
                    r_user       <= i_user_access;
                    // large page count, rounded up
                    r_left       <= {1'b0, i_length_bytes[31:22]} +
                                    pfa_pkg::CNT_W'(|i_length_bytes[21:0]);
                    r_mapd       <= {1'b0, i_virt_addr[31:22]};
                    r_res_frame  <= '0;
                    r_res_status <= (i_command == pfa_pkg::CMD_ALLOC &&
                                     i_virt_addr > pfa_pkg::KERNEL_LIMIT) ?
                                    pfa_pkg::ST_KERNEL : pfa_pkg::ST_DONE;
                end
                pfa_pkg::S_DIR_CHK: begin
                    r_tc   <= '0;
                    r_widx <= '0;
                    r_chk  <= 1'b0;
                    if (r_cmd == pfa_pkg::CMD_ALLOC) begin
                        if (dir_rd.present && dir_rd.lpage) begin
                            r_res_status <= pfa_pkg::ST_LARGE;
                        end else if (dir_rd.present && tb_rd_present) begin
                            r_res_status <= pfa_pkg::ST_MAPPED;
                        end
                    end else begin
                        if (!dir_rd.present || (!dir_rd.lpage && !tb_rd_present)) begin
                            r_res_status <= pfa_pkg::ST_NOT_MAPPED;
                        end else if (dir_rd.lpage) begin
                            r_res_status <= pfa_pkg::ST_LARGE;
                        end else begin
                            r_res_frame <= tb_rd_frame;
                        end
                    end
                end
                pfa_pkg::S_TBL_CLR: r_tc <= r_tc + pfa_pkg::CNT_W'(1);
                pfa_pkg::S_SCAN: begin
                    // one word read issued per cycle, checked the cycle after
                    if (r_widx != (WB + 1)'(WORDS)) begin
                        r_widx <= r_widx + (WB + 1)'(1);
                        r_cidx <= r_widx[WB-1:0];
                    end
                    if (scan_hit) begin
                        r_res_frame <= hit_frame;
                        r_chk       <= 1'b0;
                    end else begin
                        r_chk <= (r_widx != (WB + 1)'(WORDS));
                        if (scan_end) r_res_status <= pfa_pkg::ST_NO_FRAME;
                    end
                end
                pfa_pkg::S_MAP: begin
                    if (!map_end) begin
                        r_left <= r_left - pfa_pkg::CNT_W'(1);
                        r_mapd <= r_mapd + pfa_pkg::CNT_W'(1);
                        r_base <= r_base + pfa_pkg::DIR_BITS'(1);
                    end
                end
                pfa_pkg::S_RESP: begin
                    if (out_load) begin
                        r_status    <= r_res_status;
                        r_frame     <= 12'(r_res_frame);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_frame     = r_frame;

    // one command in flight: ready drops right after a transaction
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("command accepted while another is in flight");

    // failed operations report no frame
    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pfa_pkg::ST_DONE) |-> (o_frame == 12'd0))
        else $error("nonzero frame on a failed operation");

    // status codes stay in range
    a_status_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= pfa_pkg::ST_NOT_MAPPED))
        else $error("status code out of range");

    // no bitmap write while the scan pipeline is still fetching without a hit
    a_scan_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pfa_pkg::S_SCAN && !scan_hit) |-> !bm_wr_en)
        else $error("bitmap written during scan");

endmodule

// ===== tb/sv/tb_page_frame_allocator_with_map.sv =====
// Testbench for the page frame allocator: directed, fill, pressure and random tests.
`timescale 1ns / 1ps
module tb_page_frame_allocator_with_map;
    import pfa_pkg::*;

    localparam int          FRAMES     = 4096;
    localparam int          RESERVED   = FRAMES / 4;
    localparam int          FILL_N     = 256;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          MAX_REPORT = 10;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] frame;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_command = '0;
    logic [31:0] i_virt_addr = '0;
    logic [31:0] i_phys_addr = '0;
    logic [31:0] i_length_bytes = '0;
    logic        i_user_access = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [11:0] o_frame;

    // Predicted state of the allocator.
    logic                frame_busy [FRAMES];
    logic                pd_present [DIR_N];
    logic                pd_large   [DIR_N];
    logic                pd_user    [DIR_N];
    logic [DIR_BITS-1:0] pd_base    [DIR_N];
    logic [12:0]         pte_map    [int];   // bit 12 present, 11:0 frame

    t_result pending_results [$];
    int      mismatches = 0;
    int      snd_idle_pct = 0;
    int      rcv_stall_pct = 0;
    int      rcv_hold = 0;

    page_frame_allocator_with_map #(.FRAMES(FRAMES)) dut (.*);

    always #4 i_clk = ~i_clk;

    // Receiver: random stalls, plus a counted hold-off when requested.
    always @(negedge i_clk) begin
        if (rcv_hold > 0) begin
            i_out_ready <= 1'b0;
            rcv_hold    <= rcv_hold - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Result checker, sampled at the rising edge.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("unexpected result: status %0d frame %0d", o_status, o_frame);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status || o_frame !== exp_r.frame) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("mismatch: expected status %0d frame %0d, got status %0d frame %0d",
                                 exp_r.status, exp_r.frame, o_status, o_frame);
                end
            end
        end
    end

    function automatic void reset_model();
        foreach (frame_busy[i]) frame_busy[i] = (i < RESERVED);
        foreach (pd_present[i]) begin
            pd_present[i] = 1'b0;
            pd_large[i]   = 1'b0;
            pd_user[i]    = 1'b0;
            pd_base[i]    = '0;
        end
        pte_map.delete();
    endfunction

    function automatic t_result page_op_result(logic [1:0] cmd, logic [31:0] va,
                                               logic [31:0] pa, logic [31:0] len,
                                               logic usr);
        t_result r;
        int      d;
        int      slot;
        int      cnt;
        r    = '{status: ST_DONE, frame: '0};
        d    = va[31:22];
        slot = {va[31:22], va[21:12]};
        case (cmd)
            CMD_ALLOC: begin
                if (va > KERNEL_LIMIT) begin
                    r.status = ST_KERNEL;
                end else if (pd_present[d] && pd_large[d]) begin
                    r.status = ST_LARGE;
                end else begin
                    if (!pd_present[d]) begin
                        // new table: previous entries of this slot range are gone
                        pd_present[d] = 1'b1;
                        pd_large[d]   = 1'b0;
                        pd_user[d]    = 1'b1;
                    end
                    if (pte_map.exists(slot) && pte_map[slot][12]) begin
                        r.status = ST_MAPPED;
                    end else begin
                        r.status = ST_NO_FRAME;
                        for (int f = 0; f < FRAMES; f++) begin
                            if (!frame_busy[f]) begin
                                frame_busy[f] = 1'b1;
                                pte_map[slot] = {1'b1, 12'(f)};
                                r.status = ST_DONE;
                                r.frame  = 12'(f);
                                break;
                            end
                        end
                    end
                end
            end
            CMD_FREE: begin
                if (!pd_present[d]) begin
                    r.status = ST_NOT_MAPPED;
                end else if (pd_large[d]) begin
                    r.status = ST_LARGE;
                end else if (!(pte_map.exists(slot) && pte_map[slot][12])) begin
                    r.status = ST_NOT_MAPPED;
                end else begin
                    r.frame = pte_map[slot][11:0];
                    frame_busy[r.frame] = 1'b0;
                    pte_map.delete(slot);
                end
            end
            CMD_MAP: begin
                // count = ceil(len / 4 MiB), clipped at the end of the directory
                cnt = len[31:22] + (len[21:0] != 0);
                for (int i = 0; i < cnt && d + i < DIR_N; i++) begin
                    pd_present[d+i] = 1'b1;
                    pd_large[d+i]   = 1'b1;
                    pd_user[d+i]    = usr;
                    pd_base[d+i]    = DIR_BITS'(pa[31:22] + i);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one command transaction; entered and left at a falling edge.
    task automatic send_cmd(logic [1:0] cmd, logic [31:0] va, logic [31:0] pa = '0,
                            logic [31:0] len = '0, logic usr = 1'b0);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_virt_addr    <= va;
        i_phys_addr    <= pa;
        i_length_bytes <= len;
        i_user_access  <= usr;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(page_op_result(cmd, va, pa, len, usr));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] user_va(int d, int t);
        return {10'(d), 10'(t), 12'($urandom)};
    endfunction

    task automatic test_directed();
        send_cmd(CMD_ALLOC, 32'h0000_0000);
        send_cmd(CMD_ALLOC, 32'h0000_0FFF);           // same entry: already mapped
        send_cmd(CMD_ALLOC, KERNEL_LIMIT);            // boundary itself is allowed
        send_cmd(CMD_ALLOC, KERNEL_LIMIT + 1);        // kernel space
        send_cmd(CMD_ALLOC, 32'hFFFF_FFFF);
        send_cmd(CMD_FREE,  32'h0000_0000);
        send_cmd(CMD_FREE,  32'h0000_0000);           // entry not mapped
        send_cmd(CMD_FREE,  32'h8000_0000);           // table absent
        send_cmd(CMD_FREE,  KERNEL_LIMIT);
        send_cmd(CMD_MAP,   32'h4000_0000, 32'h1234_5678, 32'd0, 1'b1);  // maps nothing
        send_cmd(CMD_ALLOC, 32'h4000_0000);
        send_cmd(CMD_MAP,   32'h4040_0000, 32'hFFC0_0000, 32'd1, 1'b1);  // one entry
        send_cmd(CMD_MAP,   32'h4080_0000, 32'hFFC0_0000, 32'h0080_0000, 1'b0); // base wraps
        send_cmd(CMD_MAP,   32'hFF00_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1); // past the end
        send_cmd(CMD_ALLOC, 32'h4040_1000);           // inside a large page
        send_cmd(CMD_FREE,  32'hFFC0_0000);
        send_cmd(CMD_ALLOC, 32'h0C80_3000);
        send_cmd(CMD_MAP,   32'h0C80_0000, 32'h0, 32'h0040_0001, 1'b0);  // overwrite table
        send_cmd(CMD_FREE,  32'h0C80_3000);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_cmd(CMD_UNUSED, 32'h0, 32'h0, 32'h0, 1'b0);
    endtask

    // Take a run of frames within one table, then give them all back.
    task automatic test_fill();
        for (int i = 0; i < FILL_N; i++)
            send_cmd(CMD_ALLOC, user_va(100 + i / TBL_N, i % TBL_N));
        for (int i = 0; i < FILL_N; i++)
            send_cmd(CMD_FREE, user_va(100 + i / TBL_N, i % TBL_N));
    endtask

    // Receiver holds off while commands keep coming, so the block backs up.
    task automatic test_backpressure();
        rcv_hold = 400;
        for (int i = 0; i < 6; i++) send_cmd(CMD_ALLOC, user_va(2, 200 + i));
        for (int i = 0; i < 6; i++) send_cmd(CMD_FREE, user_va(2, 200 + i));
    endtask

    task automatic test_random(int items, int idle_pct, int stall_pct);
        int          pick;
        int          d;
        logic [31:0] va;
        logic [31:0] len;
        snd_idle_pct  = idle_pct;
        rcv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            // mostly a small working set of tables, some anywhere
            d  = ($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(1023);
            va = ($urandom_range(19) == 0) ? $urandom : user_va(d, $urandom_range(15));
            if (pick < 45) begin
                send_cmd(CMD_ALLOC, va);
            end else if (pick < 85) begin
                send_cmd(CMD_FREE, va);
            end else if (pick < 95) begin
                d = ($urandom_range(29) == 0) ? $urandom_range(7) : $urandom_range(16, 1023);
                case ($urandom_range(3))
                    0: len = $urandom;
                    1: len = $urandom_range(4) << 22;
                    default: len = $urandom_range(32'h0100_0000);
                endcase
                send_cmd(CMD_MAP, {10'(d), 22'($urandom)}, $urandom, len, 1'($urandom));
            end else begin
                send_cmd(CMD_UNUSED, $urandom, $urandom, $urandom, 1'($urandom));
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_fill();
        test_backpressure();
        test_random(140, 0, 0);
        test_random(140, 72, 0);
        test_random(140, 0, 72);
        test_random(140, 21, 21);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
